FILE: hw/rtl/wmmb_pkg.sv
// shared types and constants of the waveform min/max binner
// no dependencies; imported by wmmb_bin_calc and waveform_min_max_binner_core
package wmmb_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int HITS_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int BIN_CNT_W  = 13;
    localparam int BIN_IDX_W  = 12;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 64;
    localparam int MIN_BINS   = 32;

    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_TOTAL = 1'b1;

    localparam logic [BIN_CNT_W-1:0] BIN_COUNT_RESET      = 13'd1024;
    localparam logic [COUNT_W-1:0]   EXPECTED_TOTAL_RESET = 32'd24000;

    // one table entry, packed into a single ram word
    typedef struct packed {
        logic [HITS_W-1:0]          hits;
        logic signed [SAMPLE_W-1:0] max_val;
        logic signed [SAMPLE_W-1:0] min_val;
    } bin_entry_t;

    localparam int ENTRY_W = $bits(bin_entry_t);

    // operands for one bin position lookup
    typedef struct packed {
        logic [COUNT_W-1:0]   seen;
        logic [BIN_CNT_W-1:0] bin_cnt;
        logic [COUNT_W-1:0]   total;
    } bin_req_t;

endpackage

FILE: hw/rtl/wmmb_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module wmmb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hw/rtl/wmmb_bin_calc.sv
// bin position of a sample: min(bins-1, seen*bins/total), bit-serial
// shift-add multiply then restoring divide; depends on wmmb_pkg
module wmmb_bin_calc (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  wmmb_pkg::bin_req_t            req,
    output logic                          done,
    output logic [wmmb_pkg::BIN_CNT_W-1:0] bin
);
    import wmmb_pkg::*;

    localparam int PROD_W = COUNT_W + BIN_CNT_W;
    localparam int CNT_W  = $clog2(BIN_CNT_W);

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_MUL  = 3'd1;
    localparam logic [2:0] C_CHK  = 3'd2;
    localparam logic [2:0] C_DIV  = 3'd3;
    localparam logic [2:0] C_FIN  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [BIN_CNT_W-1:0] quo_reg, quo_next;
    logic [BIN_CNT_W-1:0] bsr_reg, bsr_next;
    logic [COUNT_W-1:0]   seen_reg, seen_next;
    logic [COUNT_W-1:0]   total_reg, total_next;
    logic [BIN_CNT_W-1:0] bins_reg, bins_next;
    logic [BIN_CNT_W-1:0] bin_reg, bin_next;
    logic                 done_reg, done_next;

    logic [COUNT_W:0]     trial;
    logic                 trial_ge;
    logic [COUNT_W:0]     trial_diff;
    logic [BIN_CNT_W-1:0] last_bin;

    always_comb begin
        trial      = {rem_reg, quo_reg[BIN_CNT_W-1]};
        trial_ge   = trial >= {1'b0, total_reg};
        trial_diff = trial - {1'b0, total_reg};
        last_bin   = bins_reg - BIN_CNT_W'(1);
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        bsr_next   = bsr_reg;
        seen_next  = seen_reg;
        total_next = total_reg;
        bins_next  = bins_reg;
        bin_next   = bin_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            C_IDLE: begin
                if (start) begin
                    seen_next  = req.seen;
                    total_next = req.total;
                    bins_next  = req.bin_cnt;
                    bsr_next   = req.bin_cnt;
                    prod_next  = '0;
                    cnt_next   = CNT_W'(BIN_CNT_W - 1);
                    state_next = C_MUL;
                end
            end
            C_MUL: begin
                // msb first over the bin count
                prod_next = {prod_reg[PROD_W-2:0], 1'b0}
                          + (bsr_reg[BIN_CNT_W-1] ? {{BIN_CNT_W{1'b0}}, seen_reg} : '0);
                bsr_next  = {bsr_reg[BIN_CNT_W-2:0], 1'b0};
                if (cnt_reg == '0) begin
                    state_next = C_CHK;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            C_CHK: begin
                // quotient would not fit in the bin width: clamp to last bin
                if (prod_reg[PROD_W-1:BIN_CNT_W] >= total_reg) begin
                    bin_next   = last_bin;
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end else begin
                    rem_next   = prod_reg[PROD_W-1:BIN_CNT_W];
                    quo_next   = prod_reg[BIN_CNT_W-1:0];
                    cnt_next   = CNT_W'(BIN_CNT_W - 1);
                    state_next = C_DIV;
                end
            end
            C_DIV: begin
                // dividend bits shift out the top, quotient bits in the bottom
                rem_next = trial_ge ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
                quo_next = {quo_reg[BIN_CNT_W-2:0], trial_ge};
                if (cnt_reg == '0) begin
                    state_next = C_FIN;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            C_FIN: begin
                bin_next   = (quo_reg > last_bin) ? last_bin : quo_reg;
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg   <= cnt_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        bsr_reg   <= bsr_next;
        seen_reg  <= seen_next;
        total_reg <= total_next;
        bins_reg  <= bins_next;
        bin_reg   <= bin_next;
    end

    assign done = done_reg;
    assign bin  = bin_reg;

endmodule

FILE: hw/rtl/waveform_min_max_binner_core.sv
// Min/max envelope binner: each added sample lands in bin
// min(B-1, samples_seen*B/expected_total), B being bin_count clamped to 32..MAX_BINS,
// and each bin keeps min, max and a saturating hit count in one MAX_BINS-deep ram.
// One item is handled at a time. An add is finished before the next input transfer
// can happen, going through a 13-step shift-add multiply, a range check, a 13-step
// restoring divide and a final clamp in wmmb_bin_calc, the hand-over of the bin,
// then a read-modify-write of the ram (registered read port). When the range check
// already puts the bin past the last one the divide is skipped.
// A read passes through the lookup and response states, waiting for the output
// register to drain; the result sits in that register so adds and clears continue
// meanwhile. A clear, and reset, run a pass that writes zero to every ram entry,
// one per cycle; no input transfer is taken until that pass has finished.
// Configuration writes are taken any time.
// Depends on wmmb_pkg, wmmb_bin_calc and wmmb_ram.
module waveform_min_max_binner_core #(
    parameter int MAX_BINS = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wmmb_pkg::S_DATA_W-1:0]   s_tdata,   // sample[15:0], bin_index[27:16], zero pad
    input  logic [wmmb_pkg::KIND_W-1:0]     s_tuser,   // kind[1:0]
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wmmb_pkg::M_DATA_W-1:0]   m_tdata,   // min_value[15:0], max_value[31:16],
                                                       // hits[63:32]
    output logic                            m_tuser,   // no_samples
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wmmb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wmmb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wmmb_pkg::*;

    localparam int AW = $clog2(MAX_BINS);

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_CALC = 3'd1;
    localparam logic [2:0] T_LOOK = 3'd2;
    localparam logic [2:0] T_UPD  = 3'd3;
    localparam logic [2:0] T_RESP = 3'd4;
    localparam logic [2:0] T_CLR  = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [BIN_CNT_W-1:0] bin_count_reg, bin_count_next;
    logic [COUNT_W-1:0]   total_reg, total_next;
    logic [COUNT_W-1:0]   seen_reg, seen_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic                 oob_reg, oob_next;
    logic                 is_read_reg, is_read_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    logic                 s_xfer;
    logic [SAMPLE_W-1:0]  s_sample;
    logic [BIN_IDX_W-1:0] s_bin_index;
    logic [BIN_CNT_W-1:0] bins_used;
    logic [COUNT_W-1:0]   total_eff;

    logic                 calc_start;
    bin_req_t             calc_req;
    logic                 calc_done;
    logic [BIN_CNT_W-1:0] calc_bin;

    logic                 ram_we;
    bin_entry_t           ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata_raw;
    bin_entry_t           old_entry;
    bin_entry_t           new_entry;
    logic signed [SAMPLE_W-1:0] s_val;
    logic                 out_free;

    assign s_sample    = s_tdata[SAMPLE_W-1:0];
    assign s_bin_index = s_tdata[SAMPLE_W+BIN_IDX_W-1:SAMPLE_W];
    assign s_tready    = (state_reg == T_IDLE);
    assign s_xfer      = s_tvalid && s_tready;
    assign cfg_ready   = 1'b1;
    assign out_free    = !m_tvalid_reg || m_tready;

    always_comb begin
        if (bin_count_reg < BIN_CNT_W'(MIN_BINS)) begin
            bins_used = BIN_CNT_W'(MIN_BINS);
        end else if (bin_count_reg > BIN_CNT_W'(MAX_BINS)) begin
            bins_used = BIN_CNT_W'(MAX_BINS);
        end else begin
            bins_used = bin_count_reg;
        end
        total_eff = (total_reg == '0) ? COUNT_W'(1) : total_reg;
    end

    assign calc_req.seen    = seen_reg;
    assign calc_req.bin_cnt = bins_used;
    assign calc_req.total   = total_eff;

    wmmb_bin_calc u_bin_calc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (calc_start),
        .req     (calc_req),
        .done    (calc_done),
        .bin     (calc_bin)
    );

    wmmb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BINS)
    ) u_bin_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .wr_addr (addr_reg),
        .wr_data (ram_wdata),
        .rd_addr (addr_reg),
        .rd_data (ram_rdata_raw)
    );

    assign old_entry = bin_entry_t'(ram_rdata_raw);
    assign s_val     = $signed(sample_reg);

    always_comb begin
        new_entry = old_entry;
        if (old_entry.hits == '0) begin
            new_entry.min_val = s_val;
            new_entry.max_val = s_val;
        end else begin
            if (s_val < old_entry.min_val) begin
                new_entry.min_val = s_val;
            end
            if (s_val > old_entry.max_val) begin
                new_entry.max_val = s_val;
            end
        end
        if (old_entry.hits != '1) begin
            new_entry.hits = old_entry.hits + HITS_W'(1);
        end
    end

    always_comb begin
        state_next     = state_reg;
        bin_count_next = bin_count_reg;
        total_next     = total_reg;
        seen_next      = seen_reg;
        addr_next      = addr_reg;
        sample_next    = sample_reg;
        oob_next       = oob_reg;
        is_read_next   = is_read_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        calc_start     = 1'b0;
        ram_we         = 1'b0;
        ram_wdata      = new_entry;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_BIN_COUNT:      bin_count_next = cfg_data[BIN_CNT_W-1:0];
                REG_EXPECTED_TOTAL: total_next     = cfg_data[COUNT_W-1:0];
                default:            ;
            endcase
        end

        unique case (state_reg)
            T_IDLE: begin
                if (s_xfer) begin
                    unique case (s_tuser)
                        KIND_ADD: begin
                            sample_next  = s_sample;
                            is_read_next = 1'b0;
                            calc_start   = 1'b1;
                            state_next   = T_CALC;
                        end
                        KIND_READ: begin
                            // bins beyond those in use read as empty
                            oob_next     = {1'b0, s_bin_index} >= bins_used;
                            addr_next    = s_bin_index[AW-1:0];
                            is_read_next = 1'b1;
                            state_next   = T_LOOK;
                        end
                        KIND_CLEAR: begin
                            seen_next  = '0;
                            addr_next  = '0;
                            state_next = T_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            T_CALC: begin
                if (calc_done) begin
                    addr_next  = calc_bin[AW-1:0];
                    state_next = T_LOOK;
                end
            end
            T_LOOK: begin
                state_next = is_read_reg ? T_RESP : T_UPD;
            end
            T_UPD: begin
                ram_we     = 1'b1;
                if (seen_reg != '1) begin
                    seen_next = seen_reg + COUNT_W'(1);
                end
                state_next = T_IDLE;
            end
            T_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = (seen_reg == '0);
                    if (oob_reg || old_entry.hits == '0) begin
                        m_tdata_next = '0;
                    end else begin
                        m_tdata_next = {old_entry.hits, old_entry.max_val, old_entry.min_val};
                    end
                    state_next = T_IDLE;
                end
            end
            T_CLR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (addr_reg == AW'(MAX_BINS - 1)) begin
                    state_next = T_IDLE;
                end else begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= T_CLR;
            addr_reg      <= '0;
            bin_count_reg <= BIN_COUNT_RESET;
            total_reg     <= EXPECTED_TOTAL_RESET;
            seen_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            bin_count_reg <= bin_count_next;
            total_reg     <= total_next;
            seen_reg      <= seen_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        sample_reg  <= sample_next;
        oob_reg     <= oob_next;
        is_read_reg <= is_read_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // an empty bin reports all-zero values
    a_empty_bin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[63:32] == '0) |-> (m_tdata[31:0] == '0))
        else $error("empty bin result with nonzero min or max");

    // a filled bin never reports min above max
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[63:32] != '0)
            |-> ($signed(m_tdata[15:0]) <= $signed(m_tdata[31:16])))
        else $error("bin result with min above max");

    // no hits can be reported before any sample was added
    a_no_samples_no_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[63:32] == '0))
        else $error("hits reported while no samples were added");

    // the clearing pass writes zero on every cycle
    a_clear_writes_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_CLR) |-> (ram_we && (ram_wdata == '0)))
        else $error("clearing pass missed a zero write");

    // reset starts the clearing pass, so no input is taken right after it
    a_reset_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

endmodule
